// File: rtl/lbd_pkg.sv
// Shared types and constants of the load-balancing dispatcher.
package lbd_pkg;

  // Fixed field widths of the stream items
  localparam int SID_W      = 7;
  localparam int RAND_W     = 7;
  localparam int RAND_SPAN  = 1 << RAND_W;
  localparam int LOAD_W     = 16;
  localparam int POLICY_W   = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SID_W - LOAD_W;

  // Command carried in tuser
  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  // Dispatch policy codes
  localparam logic [POLICY_W-1:0] POL_RANDOM   = 3'd0;
  localparam logic [POLICY_W-1:0] POL_SHORTEST = 3'd1;
  localparam logic [POLICY_W-1:0] POL_RR       = 3'd2;
  localparam logic [POLICY_W-1:0] POL_TWO_RAND = 3'd3;
  localparam logic [POLICY_W-1:0] POL_RR_RAND  = 3'd4;

  // Operations of the shared count unit
  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_LT  = 2'd0;
  localparam alu_op_t ALU_LE  = 2'd1;
  localparam alu_op_t ALU_INC = 2'd2;
  localparam alu_op_t ALU_DEC = 2'd3;

endpackage

// File: rtl/lbd_count_alu.sv
// Shared adder for count compares and saturating increment and decrement.
module lbd_count_alu #(
  parameter int COUNT_BITS = 16
) (
  input  lbd_pkg::alu_op_t        op,
  input  logic [COUNT_BITS-1:0]   a,
  input  logic [COUNT_BITS-1:0]   b,
  output logic                    flag,
  output logic [COUNT_BITS-1:0]   result
);

  logic [COUNT_BITS-1:0] x;
  logic [COUNT_BITS-1:0] y;
  logic                  cin;
  logic [COUNT_BITS:0]   sum;

  always_comb begin
    case (op)
      lbd_pkg::ALU_LT: begin
        x   = a;
        y   = ~b;
        cin = 1'b1;
      end
      lbd_pkg::ALU_LE: begin
        x   = b;
        y   = ~a;
        cin = 1'b1;
      end
      lbd_pkg::ALU_INC: begin
        x   = a;
        y   = '0;
        cin = 1'b1;
      end
      lbd_pkg::ALU_DEC: begin
        x   = a;
        y   = '1;
        cin = 1'b0;
      end
      default: begin
        x   = a;
        y   = '0;
        cin = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, x} + {1'b0, y} + (COUNT_BITS + 1)'(cin);

  // LT: no carry means a < b. LE: carry means b >= a.
  // INC: carry means overflow, hold. DEC: no carry means zero, hold.
  always_comb begin
    case (op)
      lbd_pkg::ALU_LT:  flag = ~sum[COUNT_BITS];
      lbd_pkg::ALU_LE:  flag = sum[COUNT_BITS];
      default:          flag = sum[COUNT_BITS];
    endcase
    case (op)
      lbd_pkg::ALU_INC: result = sum[COUNT_BITS] ? a : sum[COUNT_BITS-1:0];
      lbd_pkg::ALU_DEC: result = sum[COUNT_BITS] ? sum[COUNT_BITS-1:0] : a;
      default:          result = sum[COUNT_BITS-1:0];
    endcase
  end

endmodule

// File: rtl/load_balancing_dispatcher_unit.sv
// Top level of the load-balancing dispatcher: sequencer, count memory, ports.
//
//  channel   direction  signals                          item contents (low bit up)
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser  tuser: cmd
//                                                        tdata: server_id, rand_a, rand_b
//  m_axis    out        m_axis_tvalid/tready/tdata       tdata: chosen_server, chosen_load
//  cfg       in         cfg_valid/cfg_ready/cfg_data     balancing policy code
//
// Each item runs through the sequencer states in order: RDA, RDB, then CMP for
// two candidates or SCAN over every server, then UPD, then EMIT for a dispatch; a
// completion with an out-of-range server is dropped in IDLE. The count memory has one read
// and one write port; the shortest-queue scan reads one count per cycle through it
// and the single shared adder does each compare and each count update.
// After reset a clearing pass writes zero to every count, while
// s_axis_tready stays low; cfg writes are taken throughout.
// A finished result waits in the output register; the block returns to ready once
// it is loaded there, so a stall on m_axis holds only the next dispatch's result.
module load_balancing_dispatcher_unit #(
  parameter int SERVERS    = 128,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lbd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // server_id, rand_a, rand_b
  input  logic                               s_axis_tuser,   // cmd
  // Result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lbd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // chosen_server, chosen_load
  // Policy register write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lbd_pkg::POLICY_W-1:0]       cfg_data        // policy code
);

  localparam int IDX_W = $clog2(SERVERS);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDA   = 3'd2;
  localparam logic [2:0] S_RDB   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // Candidate modes
  localparam logic [1:0] M_SINGLE = 2'd0;
  localparam logic [1:0] M_PAIR   = 2'd1;
  localparam logic [1:0] M_SCAN   = 2'd2;

  // Random index reduced modulo SERVERS, worked out at elaboration
  typedef logic [lbd_pkg::RAND_SPAN-1:0][IDX_W-1:0] mod_tab_t;

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t t;
    for (int i = 0; i < lbd_pkg::RAND_SPAN; i++) begin
      t[i] = IDX_W'(i % SERVERS);
    end
    return t;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(SERVERS - 1)) ? '0 : x + IDX_W'(1);
  endfunction

  // Unpack the input item
  logic [lbd_pkg::SID_W-1:0]  in_sid;
  logic [lbd_pkg::RAND_W-1:0] in_ra;
  logic [lbd_pkg::RAND_W-1:0] in_rb;
  logic [IDX_W-1:0]           ra_m;
  logic [IDX_W-1:0]           rb_m;
  logic                       sid_ok;

  assign in_sid = s_axis_tdata[lbd_pkg::SID_W-1:0];
  assign in_ra  = s_axis_tdata[lbd_pkg::SID_W +: lbd_pkg::RAND_W];
  assign in_rb  = s_axis_tdata[lbd_pkg::SID_W + lbd_pkg::RAND_W +: lbd_pkg::RAND_W];
  assign ra_m   = MOD_TAB[in_ra];
  assign rb_m   = MOD_TAB[in_rb];
  assign sid_ok = ({{(32 - lbd_pkg::SID_W){1'b0}}, in_sid} < 32'(SERVERS));

  // Control registers
  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [lbd_pkg::POLICY_W-1:0] policy;
  logic [IDX_W-1:0]            rr;
  logic                        out_valid;

  // Working registers
  logic                        cmd;
  logic [1:0]                  mode;
  logic [IDX_W-1:0]            cand_a;   // also the clearing address
  logic [IDX_W-1:0]            cand_b;   // also the scan index
  logic [IDX_W-1:0]            best_idx;
  logic [COUNT_BITS-1:0]       best_load;
  logic [lbd_pkg::SID_W-1:0]   out_server;
  logic [lbd_pkg::LOAD_W-1:0]  out_load;

  // Count memory
  logic [COUNT_BITS-1:0]       mem [SERVERS];
  logic [IDX_W-1:0]            rd_addr;
  logic [COUNT_BITS-1:0]       rd_data;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [COUNT_BITS-1:0]       mem_wdata;

  // Shared count unit
  lbd_pkg::alu_op_t            alu_op;
  logic [COUNT_BITS-1:0]       alu_a;
  logic [COUNT_BITS-1:0]       alu_b;
  logic                        alu_flag;
  logic [COUNT_BITS-1:0]       alu_result;

  logic                        out_free;
  logic                        in_take;

  assign out_free      = ~out_valid | m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;

  lbd_count_alu #(
    .COUNT_BITS (COUNT_BITS)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .flag   (alu_flag),
    .result (alu_result)
  );

  // Feed the shared unit: scan compare, pair compare, or count update
  always_comb begin
    case (state)
      S_SCAN: begin
        alu_op = lbd_pkg::ALU_LT;
        alu_a  = rd_data;
        alu_b  = best_load;
      end
      S_CMP: begin
        alu_op = lbd_pkg::ALU_LE;
        alu_a  = best_load;
        alu_b  = rd_data;
      end
      default: begin
        alu_op = (cmd == lbd_pkg::CMD_COMPLETE) ? lbd_pkg::ALU_DEC : lbd_pkg::ALU_INC;
        alu_a  = best_load;
        alu_b  = rd_data;
      end
    endcase
  end

  // Memory addressing
  always_comb begin
    case (state)
      S_RDB:   rd_addr = cand_b;
      S_SCAN:  rd_addr = wrap_inc(cand_b);
      default: rd_addr = cand_a;
    endcase
  end

  assign mem_we    = (state == S_CLEAR) | (state == S_UPD);
  assign mem_waddr = (state == S_CLEAR) ? cand_a : best_idx;
  assign mem_wdata = (state == S_CLEAR) ? '0 : alu_result;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (cand_a == IDX_W'(SERVERS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          if (s_axis_tuser == lbd_pkg::CMD_COMPLETE && !sid_ok) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_RDA;
          end
        end
      end
      S_RDA: state_next = S_RDB;
      S_RDB: begin
        case (mode)
          M_PAIR:  state_next = S_CMP;
          M_SCAN:  state_next = S_SCAN;
          default: state_next = S_UPD;
        endcase
      end
      S_CMP: state_next = S_UPD;
      S_SCAN: begin
        if (cand_b == IDX_W'(SERVERS - 1)) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = (cmd == lbd_pkg::CMD_COMPLETE) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      policy    <= lbd_pkg::POL_RANDOM;
      rr        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        policy <= cfg_data;
      end
      // Advance the round-robin pointer on dispatches that draw from it
      if (in_take && s_axis_tuser == lbd_pkg::CMD_DISPATCH &&
          (policy == lbd_pkg::POL_RR || policy == lbd_pkg::POL_RR_RAND)) begin
        rr <= wrap_inc(rr);
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Clearing address; first candidate taken on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_a <= '0;
    end else if (state == S_CLEAR) begin
      cand_a <= wrap_inc(cand_a);
    end else if (in_take) begin
      if (s_axis_tuser == lbd_pkg::CMD_COMPLETE) begin
        cand_a <= IDX_W'(in_sid);
      end else begin
        case (policy)
          lbd_pkg::POL_SHORTEST: cand_a <= '0;
          lbd_pkg::POL_RR:       cand_a <= rr;
          lbd_pkg::POL_RR_RAND:  cand_a <= rr;
          default:               cand_a <= ra_m;
        endcase
      end
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd <= s_axis_tuser;
          if (s_axis_tuser == lbd_pkg::CMD_COMPLETE) begin
            mode <= M_SINGLE;
          end else begin
            case (policy)
              lbd_pkg::POL_SHORTEST: begin
                mode   <= M_SCAN;
                cand_b <= IDX_W'(1);
              end
              lbd_pkg::POL_TWO_RAND: begin
                mode   <= M_PAIR;
                cand_b <= (rb_m == ra_m) ? wrap_inc(rb_m) : rb_m;
              end
              lbd_pkg::POL_RR_RAND: begin
                mode   <= M_PAIR;
                cand_b <= (rb_m == rr) ? wrap_inc(rb_m) : rb_m;
              end
              default: begin
                mode <= M_SINGLE;
              end
            endcase
          end
        end
      end
      S_RDB: begin
        // Hold the first candidate as the current best
        best_idx  <= cand_a;
        best_load <= rd_data;
      end
      S_CMP: begin
        // First candidate wins ties
        if (!alu_flag) begin
          best_idx  <= cand_b;
          best_load <= rd_data;
        end
      end
      S_SCAN: begin
        // Strictly lower count replaces, so the lowest index wins ties
        if (alu_flag) begin
          best_idx  <= cand_b;
          best_load <= rd_data;
        end
        cand_b <= wrap_inc(cand_b);
      end
      S_EMIT: begin
        if (out_free) begin
          out_server <= lbd_pkg::SID_W'(best_idx);
          out_load   <= lbd_pkg::LOAD_W'(best_load);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{lbd_pkg::OUT_PAD_W{1'b0}}, out_load, out_server};

endmodule
